// ----- sv/lzo_pkg.sv -----
`timescale 1ns / 1ps

package lzo_pkg;

  localparam int MAX_LAYERS = 16;
  localparam int ID_W       = 4;
  localparam int HGT_W      = 5;
  localparam int REQ_W      = 6;
  localparam int EXT_W      = 7;

  typedef logic [ID_W-1:0]         id_t;
  typedef logic signed [HGT_W-1:0] hgt_t;
  typedef logic signed [EXT_W-1:0] hext_t;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_SET   = 2'd1,
    KIND_FREE  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic  en;
    logic  shift_en;
    logic  shift_up;
    hext_t lo;
    hext_t hi;
    logic  place;
    hext_t place_pos;
    logic  tgt_wr;
    id_t   tgt_id;
    logic  tgt_used;
    hgt_t  tgt_height;
  } op_t;

  function automatic hext_t ext_hgt(input hgt_t h);
    ext_hgt = hext_t'(h);
  endfunction

endpackage

// ----- sv/lzo_slot_cell.sv -----
`timescale 1ns / 1ps

module lzo_slot_cell import lzo_pkg::*; #(
  parameter id_t SLOT = '0
) (
  input  logic clk,
  input  logic rst,
  input  op_t  op,
  output logic used,
  output hgt_t height
);

  hext_t h_ext;
  logic  in_range;

  assign h_ext    = ext_hgt(height);
  assign in_range = (h_ext >= op.lo) && (h_ext <= op.hi);

  always_ff @(posedge clk) begin
    if (rst) begin
      used   <= 1'b0;
      height <= -5'sd1;
    end else if (op.en) begin
      if (op.tgt_wr && (op.tgt_id == SLOT)) begin
        used   <= op.tgt_used;
        height <= op.tgt_height;
      end else if (op.shift_en && used && in_range) begin
        if (op.shift_up) begin
          height <= height + 5'sd1;
        end else begin
          height <= height - 5'sd1;
        end
      end
    end
  end

endmodule

// ----- sv/lzo_order_cell.sv -----
`timescale 1ns / 1ps

module lzo_order_cell import lzo_pkg::*; #(
  parameter int POS = 0
) (
  input  logic clk,
  input  op_t  op,
  input  id_t  below_id,
  input  id_t  above_id,
  output id_t  layer
);

  localparam hext_t POS_X = hext_t'(POS);

  always_ff @(posedge clk) begin
    if (op.en) begin
      if (op.place && (op.place_pos == POS_X)) begin
        layer <= op.tgt_id;
      end else if (op.shift_en && op.shift_up &&
                   (POS_X >= op.lo + 7'sd1) && (POS_X <= op.hi + 7'sd1)) begin
        layer <= below_id;
      end else if (op.shift_en && !op.shift_up &&
                   (POS_X >= op.lo - 7'sd1) && (POS_X <= op.hi - 7'sd1)) begin
        layer <= above_id;
      end
    end
  end

endmodule

// ----- sv/layer_z_order_manager_top.sv -----
`timescale 1ns / 1ps

// Keeps sixteen layer slots and the bottom-to-top order of the visible ones. Each
// command is taken as one transfer on the slave side and returns one transfer on
// the master side; a command is captured in the idle state and executed in the
// exec state, in which the affected part of the order row shifts by one place in
// parallel while the affected slots renumber themselves. The exec state is held
// while an earlier result waits to be taken. Allocation reports failure when every
// slot is in use, and a height request is clamped to the current stack.

module layer_z_order_manager_top import lzo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // layer_id[3:0], new_height[9:4], zero fill
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // ok[0], result_layer[4:1], final_height[9:5],
                                 // top_index[14:10], zero fill
);

  state_t state, state_next;

  kind_t             kind;
  id_t               layer_id;
  logic [REQ_W-1:0]  new_height;
  hgt_t              top_height, top_height_next;

  logic [MAX_LAYERS-1:0] used;
  hgt_t                  heights [MAX_LAYERS];
  id_t                   order   [MAX_LAYERS];

  op_t   op;
  logic  fire;
  logic  ok;
  id_t   res;
  hgt_t  fh;
  hext_t old_h, top_x, lim, req_x, rc;
  logic  any_free;
  id_t   free_id;

  always_comb begin
    any_free = 1'b0;
    free_id  = '0;
    for (int i = MAX_LAYERS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        any_free = 1'b1;
        free_id  = id_t'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      kind       <= kind_t'(s_tuser);
      layer_id   <= s_tdata[3:0];
      new_height <= s_tdata[9:4];
    end
  end

  always_comb begin
    old_h = ext_hgt(heights[layer_id]);
    top_x = ext_hgt(top_height);
    req_x = hext_t'($signed(new_height));
    lim   = (old_h >= 7'sd0) ? top_x : top_x + 7'sd1;
    rc    = req_x;
    if (rc > lim) begin
      rc = lim;
    end
    if (rc < -7'sd1) begin
      rc = -7'sd1;
    end
  end

  always_comb begin
    state_next      = state;
    s_tready        = (state == ST_IDLE);
    fire            = (state == ST_EXEC) && (!m_tvalid || m_tready);
    top_height_next = top_height;
    ok              = 1'b1;
    res             = '0;
    fh              = -5'sd1;
    op              = '0;
    op.tgt_id       = layer_id;
    op.place_pos    = rc;
    op.tgt_height   = -5'sd1;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    case (kind)
      KIND_ALLOC: begin
        if (any_free) begin
          res         = free_id;
          op.tgt_wr   = 1'b1;
          op.tgt_id   = free_id;
          op.tgt_used = 1'b1;
        end else begin
          ok = 1'b0;
        end
      end
      KIND_SET: begin
        res = layer_id;
        if (!used[layer_id]) begin
          ok = 1'b0;
        end else begin
          fh            = hgt_t'(rc);
          op.tgt_wr     = 1'b1;
          op.tgt_used   = 1'b1;
          op.tgt_height = hgt_t'(rc);
          if (old_h > rc) begin
            op.shift_en = 1'b1;
            if (rc >= 7'sd0) begin
              op.shift_up = 1'b1;
              op.lo       = rc;
              op.hi       = old_h - 7'sd1;
              op.place    = 1'b1;
            end else begin
              op.lo           = old_h + 7'sd1;
              op.hi           = top_x;
              top_height_next = top_height - 5'sd1;
            end
          end else if (old_h < rc) begin
            op.shift_en = 1'b1;
            op.place    = 1'b1;
            if (old_h >= 7'sd0) begin
              op.lo = old_h + 7'sd1;
              op.hi = rc;
            end else begin
              op.shift_up     = 1'b1;
              op.lo           = rc;
              op.hi           = top_x;
              top_height_next = top_height + 5'sd1;
            end
          end
        end
      end
      KIND_FREE: begin
        res         = layer_id;
        op.tgt_wr   = 1'b1;
        op.tgt_used = 1'b0;
        if (old_h >= 7'sd0) begin
          op.shift_en     = 1'b1;
          op.lo           = old_h + 7'sd1;
          op.hi           = top_x;
          top_height_next = top_height - 5'sd1;
        end
      end
      default: begin
      end
    endcase

    op.en = fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_height <= -5'sd1;
      m_tvalid   <= 1'b0;
    end else begin
      if (fire) begin
        top_height <= top_height_next;
        m_tvalid   <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {1'b0, top_height_next, fh, res, ok};
    end
  end

  for (genvar g = 0; g < MAX_LAYERS; g++) begin : g_cells
    id_t below_id, above_id;

    if (g == 0) begin : g_bottom
      assign below_id = '0;
    end else begin : g_below
      assign below_id = order[g-1];
    end

    if (g == MAX_LAYERS - 1) begin : g_top
      assign above_id = '0;
    end else begin : g_above
      assign above_id = order[g+1];
    end

    lzo_slot_cell #(
      .SLOT (id_t'(g))
    ) u_slot (
      .clk    (clk),
      .rst    (rst),
      .op     (op),
      .used   (used[g]),
      .height (heights[g])
    );

    lzo_order_cell #(
      .POS (g)
    ) u_order (
      .clk      (clk),
      .op       (op),
      .below_id (below_id),
      .above_id (above_id),
      .layer    (order[g])
    );
  end

endmodule
